// ===== hdl/psc_pkg.sv =====
// Package: shared constants and types for the pedal sensor plausibility check.
`timescale 1ns / 1ps
`default_nettype none

package psc_pkg;

    // Default raw sample width
    localparam int DEF_ADC_BITS = 10;

    // Scaled position range and width
    localparam int SCALE     = 1000;
    localparam int POS_W     = 10;
    localparam int QUO_BITS  = 10;
    localparam int PERMILLE_W = 10;

    // Register reset values (truncated to the width of the register where they land)
    localparam int RST_REST      = 0;
    localparam int RST_FULL      = 1023;
    localparam int RST_RAIL_LOW  = 50;
    localparam int RST_RAIL_HIGH = 975;
    localparam int RST_MAX_DIFF  = 100;
    localparam int RST_MIN_DELTA = 50;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_REST_A    = 3'd0,
        REG_FULL_A    = 3'd1,
        REG_REST_B    = 3'd2,
        REG_FULL_B    = 3'd3,
        REG_RAIL_LOW  = 3'd4,
        REG_RAIL_HIGH = 3'd5,
        REG_MAX_DIFF  = 3'd6,
        REG_MIN_DELTA = 3'd7
    } psc_reg_t;

    // Saturation override carried down a lane's divider pipeline
    typedef enum logic [1:0] {
        SAT_NONE = 2'd0,
        SAT_ZERO = 2'd1,
        SAT_MAX  = 2'd2
    } psc_sat_t;

    // Per-item control and raw-sample faults traveling beside the lanes
    typedef struct packed {
        logic vld;
        logic short_f;
        logic similar_f;
    } psc_flags_t;

endpackage

`default_nettype wire

// ===== hdl/psc_lane.sv =====
// Lane: clamp one channel and scale it to permille with a pipelined divider.
`timescale 1ns / 1ps
`default_nettype none

module psc_lane
    import psc_pkg::*;
#(
    parameter int ADC_BITS = DEF_ADC_BITS
)
(
    input  wire logic                clk,
    input  wire logic [ADC_BITS-1:0] raw,
    input  wire logic [ADC_BITS-1:0] rest,
    input  wire logic [ADC_BITS-1:0] full,
    output logic      [POS_W-1:0]    pos
);

    localparam int NUM_W = ADC_BITS + QUO_BITS;

    logic [ADC_BITS-1:0] v_lo;
    logic [ADC_BITS-1:0] v_clamp;
    logic [ADC_BITS-1:0] den;
    logic [NUM_W-1:0]    num_next;
    psc_sat_t            sat_next;

    logic [NUM_W-1:0]    rem_reg [QUO_BITS+1];
    logic [QUO_BITS-1:0] q_reg   [QUO_BITS+1];
    psc_sat_t            sat_reg [QUO_BITS+1];

    // Clamp to [rest, full] and form the numerator
    always_comb
    begin
        v_lo     = (raw < rest) ? rest : raw;
        v_clamp  = (v_lo > full) ? full : v_lo;
        den      = full - rest;
        num_next = NUM_W'(v_clamp - rest) * NUM_W'(SCALE);
        if (full == rest)
        begin
            sat_next = SAT_ZERO;
        end
        else if (full < rest)
        begin
            sat_next = SAT_MAX;
        end
        else
        begin
            sat_next = SAT_NONE;
        end
    end

    // Input stage
    always_ff @(posedge clk)
    begin
        rem_reg[0] <= num_next;
        q_reg[0]   <= '0;
        sat_reg[0] <= sat_next;
    end

    // One quotient bit per stage, MSB first
    for (genvar i = 0; i < QUO_BITS; i++)
    begin : g_stage
        logic [NUM_W-1:0] den_sh;
        logic             ge;
        logic [NUM_W-1:0] rem_next;

        always_comb
        begin
            den_sh   = NUM_W'(den) << (QUO_BITS - 1 - i);
            ge       = (rem_reg[i] >= den_sh);
            rem_next = ge ? (rem_reg[i] - den_sh) : rem_reg[i];
        end

        always_ff @(posedge clk)
        begin
            rem_reg[i+1] <= rem_next;
            q_reg[i+1]   <= {q_reg[i][QUO_BITS-2:0], ge};
            sat_reg[i+1] <= sat_reg[i];
        end
    end

    // Apply the degenerate-calibration overrides
    always_comb
    begin
        case (sat_reg[QUO_BITS])
            SAT_ZERO: pos = '0;
            SAT_MAX:  pos = POS_W'(SCALE);
            default:  pos = POS_W'(q_reg[QUO_BITS]);
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/psc_merge.sv =====
// Merge stage: compare the two lane positions and register the result.
`timescale 1ns / 1ps
`default_nettype none

module psc_merge
    import psc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire psc_flags_t            flags,
    input  wire logic [POS_W-1:0]      lane_pos_a,
    input  wire logic [POS_W-1:0]      lane_pos_b,
    input  wire logic [PERMILLE_W-1:0] max_diff_permille,
    output logic                       done,
    output logic      [POS_W-1:0]      pos_a,
    output logic      [POS_W-1:0]      pos_b,
    output logic                       diff_fault,
    output logic                       short_fault,
    output logic                       similar_fault
);

    logic [POS_W-1:0] dpos;
    logic             done_reg;
    logic [POS_W-1:0] pos_a_reg;
    logic [POS_W-1:0] pos_b_reg;
    logic             diff_reg;
    logic             short_reg;
    logic             similar_reg;

    // Absolute position difference
    always_comb
    begin
        dpos = (lane_pos_a > lane_pos_b) ? (lane_pos_a - lane_pos_b)
                                         : (lane_pos_b - lane_pos_a);
    end

    // Strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= flags.vld;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        pos_a_reg   <= lane_pos_a;
        pos_b_reg   <= lane_pos_b;
        diff_reg    <= (PERMILLE_W'(dpos) > max_diff_permille);
        short_reg   <= flags.short_f;
        similar_reg <= flags.similar_f;
    end

    assign done          = done_reg;
    assign pos_a         = pos_a_reg;
    assign pos_b         = pos_b_reg;
    assign diff_fault    = diff_reg;
    assign short_fault   = short_reg;
    assign similar_fault = similar_reg;

    // Scaled positions never leave the permille range
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (pos_a <= POS_W'(SCALE)) && (pos_b <= POS_W'(SCALE)))
        else $error("scaled position above full travel");

    // Equal positions never raise a difference fault
    a_diff_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (pos_a == pos_b) |-> !diff_fault)
        else $error("difference fault on equal positions");

endmodule

`default_nettype wire

// ===== hdl/pedal_sensor_plausibility_check.sv =====
// Top level: config registers, two scaling lanes, raw-sample faults and merge.
// Results are registered through the lane input and divider stages, then the merge stage.
// Throughput: one sample pair per cycle; the pipelined one-bit-per-stage
//   dividers in each lane set the latency, busy stays low.
// The receiver cannot stall: done is high for exactly one cycle per result.
// Reset (rst_n low, async) clears the pipeline valids and loads the
//   calibration registers with their default values.
`timescale 1ns / 1ps
`default_nettype none

module pedal_sensor_plausibility_check
    import psc_pkg::*;
#(
    parameter int ADC_BITS = DEF_ADC_BITS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Sample transaction
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [ADC_BITS-1:0]   raw_a,
    input  wire logic [ADC_BITS-1:0]   raw_b,
    // Configuration write transaction
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [2:0]            cfg_index,
    input  wire logic [((ADC_BITS+1 > PERMILLE_W) ? ADC_BITS+1 : PERMILLE_W)-1:0] cfg_data,
    // Result
    output logic                       done,
    output logic      [POS_W-1:0]      pos_a,
    output logic      [POS_W-1:0]      pos_b,
    output logic                       diff_fault,
    output logic                       short_fault,
    output logic                       similar_fault
);

    localparam int LAT = QUO_BITS + 2;

    logic [ADC_BITS-1:0]   rest_a_reg;
    logic [ADC_BITS-1:0]   full_a_reg;
    logic [ADC_BITS-1:0]   rest_b_reg;
    logic [ADC_BITS-1:0]   full_b_reg;
    logic [ADC_BITS-1:0]   rail_low_reg;
    logic [ADC_BITS-1:0]   rail_high_reg;
    logic [PERMILLE_W-1:0] max_diff_reg;
    logic [ADC_BITS:0]     min_delta_reg;

    logic                  accept;
    logic [ADC_BITS-1:0]   draw;
    psc_flags_t            flags_next;
    psc_flags_t            flags_reg [QUO_BITS+1];
    logic [POS_W-1:0]      lane_pos_a;
    logic [POS_W-1:0]      lane_pos_b;

    // Always ready: the pipeline takes a pair every cycle
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rest_a_reg    <= ADC_BITS'(RST_REST);
            full_a_reg    <= ADC_BITS'(RST_FULL);
            rest_b_reg    <= ADC_BITS'(RST_REST);
            full_b_reg    <= ADC_BITS'(RST_FULL);
            rail_low_reg  <= ADC_BITS'(RST_RAIL_LOW);
            rail_high_reg <= ADC_BITS'(RST_RAIL_HIGH);
            max_diff_reg  <= PERMILLE_W'(RST_MAX_DIFF);
            min_delta_reg <= (ADC_BITS+1)'(RST_MIN_DELTA);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (psc_reg_t'(cfg_index))
                REG_REST_A:    rest_a_reg    <= cfg_data[ADC_BITS-1:0];
                REG_FULL_A:    full_a_reg    <= cfg_data[ADC_BITS-1:0];
                REG_REST_B:    rest_b_reg    <= cfg_data[ADC_BITS-1:0];
                REG_FULL_B:    full_b_reg    <= cfg_data[ADC_BITS-1:0];
                REG_RAIL_LOW:  rail_low_reg  <= cfg_data[ADC_BITS-1:0];
                REG_RAIL_HIGH: rail_high_reg <= cfg_data[ADC_BITS-1:0];
                REG_MAX_DIFF:  max_diff_reg  <= cfg_data[PERMILLE_W-1:0];
                REG_MIN_DELTA: min_delta_reg <= cfg_data[ADC_BITS:0];
                default:       ;
            endcase
        end
    end

    // Raw-sample faults, evaluated at accept
    always_comb
    begin
        draw = (raw_a > raw_b) ? (raw_a - raw_b) : (raw_b - raw_a);
        flags_next.vld       = accept;
        flags_next.short_f   = (raw_a <= rail_low_reg) || (raw_a >= rail_high_reg) ||
                               (raw_b <= rail_low_reg) || (raw_b >= rail_high_reg);
        flags_next.similar_f = ({1'b0, draw} < min_delta_reg);
    end

    // Flag delay line matching the lane pipelines
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= QUO_BITS; i++)
            begin
                flags_reg[i] <= '0;
            end
        end
        else
        begin
            flags_reg[0] <= flags_next;
            for (int i = 0; i < QUO_BITS; i++)
            begin
                flags_reg[i+1] <= flags_reg[i];
            end
        end
    end

    // Scaling lanes
    psc_lane #(.ADC_BITS(ADC_BITS)) u_lane_a (
        .clk  (clk),
        .raw  (raw_a),
        .rest (rest_a_reg),
        .full (full_a_reg),
        .pos  (lane_pos_a)
    );

    psc_lane #(.ADC_BITS(ADC_BITS)) u_lane_b (
        .clk  (clk),
        .raw  (raw_b),
        .rest (rest_b_reg),
        .full (full_b_reg),
        .pos  (lane_pos_b)
    );

    // Merge and output register
    psc_merge u_merge (
        .clk               (clk),
        .rst_n             (rst_n),
        .flags             (flags_reg[QUO_BITS]),
        .lane_pos_a        (lane_pos_a),
        .lane_pos_b        (lane_pos_b),
        .max_diff_permille (max_diff_reg),
        .done              (done),
        .pos_a             (pos_a),
        .pos_b             (pos_b),
        .diff_fault        (diff_fault),
        .short_fault       (short_fault),
        .similar_fault     (similar_fault)
    );

    // Every result traces back to a sample transaction a fixed time earlier
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LAT))
        else $error("result without a matching sample transaction");

    // Every sample transaction yields a result
    a_done_follow: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LAT done)
        else $error("sample transaction produced no result");

    // Identical raw samples are always too similar when a delta is required
    a_similar: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (raw_a == raw_b) && (min_delta_reg != '0) |=> flags_reg[0].similar_f)
        else $error("identical samples not flagged as similar");

endmodule

`default_nettype wire

// ===== tb/sv/psc_position_checker.sv =====
// Checker: predicts each pedal result from the observed transactions and compares.
`timescale 1ns / 1ps

module psc_position_checker
    import psc_pkg::*;
#(
    parameter int ADC_BITS = DEF_ADC_BITS,
    parameter int CFG_W    = (ADC_BITS + 1 > PERMILLE_W) ? ADC_BITS + 1 : PERMILLE_W
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic                busy,
    input  wire logic [ADC_BITS-1:0] raw_a,
    input  wire logic [ADC_BITS-1:0] raw_b,
    input  wire logic                cfg_valid,
    input  wire logic                cfg_ready,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [CFG_W-1:0]    cfg_data,
    input  wire logic                done,
    input  wire logic [POS_W-1:0]    pos_a,
    input  wire logic [POS_W-1:0]    pos_b,
    input  wire logic                diff_fault,
    input  wire logic                short_fault,
    input  wire logic                similar_fault,
    output int                       mismatch_count,
    output int                       outstanding
);

    typedef struct packed {
        logic [POS_W-1:0] pos_a;
        logic [POS_W-1:0] pos_b;
        logic             diff_f;
        logic             short_f;
        logic             similar_f;
    } pedal_result_t;

    // Local copy of the calibration registers
    logic [ADC_BITS-1:0]   cal_rest_a, cal_full_a, cal_rest_b, cal_full_b;
    logic [ADC_BITS-1:0]   cal_rail_low, cal_rail_high;
    logic [PERMILLE_W-1:0] cal_max_diff;
    logic [ADC_BITS:0]     cal_min_delta;

    pedal_result_t expected_pedal_q[$];
    pedal_result_t observed, oldest;
    int            errors = 0;

    assign mismatch_count = errors;

    // Clamp to [rest, full], then map linearly onto 0..1000
    function automatic logic [POS_W-1:0] scale_to_permille(
        input logic [ADC_BITS-1:0] sample,
        input logic [ADC_BITS-1:0] rest,
        input logic [ADC_BITS-1:0] full
    );
        int v;
        int r;
        int f;
        int q;
        v = int'(sample);
        r = int'(rest);
        f = int'(full);
        if (v < r)
            v = r;
        if (v > f)
            v = f;
        if (f == r)
            return '0;
        q = ((v - r) * SCALE) / (f - r);  // truncates toward zero
        if (q < 0)
            q = 0;
        if (q > SCALE)
            q = SCALE;
        return q[POS_W-1:0];
    endfunction

    function automatic pedal_result_t predict_pedal(
        input logic [ADC_BITS-1:0] a,
        input logic [ADC_BITS-1:0] b
    );
        pedal_result_t res;
        logic [POS_W-1:0]    dpos;
        logic [ADC_BITS-1:0] draw;
        res.pos_a = scale_to_permille(a, cal_rest_a, cal_full_a);
        res.pos_b = scale_to_permille(b, cal_rest_b, cal_full_b);
        dpos = (res.pos_a > res.pos_b) ? res.pos_a - res.pos_b : res.pos_b - res.pos_a;
        draw = (a > b) ? a - b : b - a;
        res.diff_f    = (dpos > cal_max_diff);
        res.short_f   = (a <= cal_rail_low) || (a >= cal_rail_high) ||
                        (b <= cal_rail_low) || (b >= cal_rail_high);
        res.similar_f = ({1'b0, draw} < cal_min_delta);
        return res;
    endfunction

    task automatic note_failure(input string what, input pedal_result_t want,
                                input pedal_result_t got);
        errors++;
        if (errors <= 10)
            $display({"%0t %s: expected pos_a=%0d pos_b=%0d diff=%b short=%b similar=%b,",
                      " got pos_a=%0d pos_b=%0d diff=%b short=%b similar=%b"},
                     $time, what, want.pos_a, want.pos_b, want.diff_f, want.short_f,
                     want.similar_f, got.pos_a, got.pos_b, got.diff_f, got.short_f,
                     got.similar_f);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_rest_a    <= ADC_BITS'(RST_REST);
            cal_full_a    <= ADC_BITS'(RST_FULL);
            cal_rest_b    <= ADC_BITS'(RST_REST);
            cal_full_b    <= ADC_BITS'(RST_FULL);
            cal_rail_low  <= ADC_BITS'(RST_RAIL_LOW);
            cal_rail_high <= ADC_BITS'(RST_RAIL_HIGH);
            cal_max_diff  <= PERMILLE_W'(RST_MAX_DIFF);
            cal_min_delta <= (ADC_BITS + 1)'(RST_MIN_DELTA);
            expected_pedal_q.delete();
            outstanding <= 0;
        end
        else
        begin
            // Register write transaction; values masked to register widths
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_REST_A:    cal_rest_a    <= cfg_data[ADC_BITS-1:0];
                    REG_FULL_A:    cal_full_a    <= cfg_data[ADC_BITS-1:0];
                    REG_REST_B:    cal_rest_b    <= cfg_data[ADC_BITS-1:0];
                    REG_FULL_B:    cal_full_b    <= cfg_data[ADC_BITS-1:0];
                    REG_RAIL_LOW:  cal_rail_low  <= cfg_data[ADC_BITS-1:0];
                    REG_RAIL_HIGH: cal_rail_high <= cfg_data[ADC_BITS-1:0];
                    REG_MAX_DIFF:  cal_max_diff  <= cfg_data[PERMILLE_W-1:0];
                    REG_MIN_DELTA: cal_min_delta <= cfg_data[ADC_BITS:0];
                    default: ;
                endcase
            end

            // Sample transaction
            if (start && !busy)
                expected_pedal_q.push_back(predict_pedal(raw_a, raw_b));

            // Result transaction
            if (done)
            begin
                observed = '{pos_a, pos_b, diff_fault, short_fault, similar_fault};
                if (expected_pedal_q.size() == 0)
                    note_failure("unexpected result", '0, observed);
                else
                begin
                    oldest = expected_pedal_q.pop_front();
                    if (observed !== oldest)
                        note_failure("result mismatch", oldest, observed);
                end
            end

            outstanding <= expected_pedal_q.size();
        end
    end

endmodule

// ===== tb/sv/pedal_sensor_plausibility_check_tb.sv =====
// Testbench top: clock, reset, calibration and sample stimulus, and final verdict.
`timescale 1ns / 1ps

module pedal_sensor_plausibility_check_tb;
    import psc_pkg::*;

    localparam int ADC_BITS     = DEF_ADC_BITS;
    localparam int CFG_W        = (ADC_BITS + 1 > PERMILLE_W) ? ADC_BITS + 1 : PERMILLE_W;
    localparam int RAW_MAX      = (1 << ADC_BITS) - 1;
    localparam int DRAIN_CYCLES = 24;
    localparam int PHASE_ITEMS  = 210;

    typedef enum {CAL_TYPICAL, CAL_ZEROS, CAL_ONES, CAL_INVERTED, CAL_RANDOM} cal_kind_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [ADC_BITS-1:0] raw_a = '0;
    logic [ADC_BITS-1:0] raw_b = '0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [2:0]          cfg_index = '0;
    logic [CFG_W-1:0]    cfg_data = '0;
    logic                done;
    logic [POS_W-1:0]    pos_a, pos_b;
    logic                diff_fault, short_fault, similar_fault;
    int                  mismatch_count;
    int                  outstanding;

    // Stimulus steering: calibration as last programmed
    logic [CFG_W-1:0] cal_word [8];
    int               lo_a, hi_a, lo_b, hi_b, rail_lo, rail_hi;
    int               sender_idle_pct = 0;
    cal_kind_t        schedule [8] = '{CAL_TYPICAL, CAL_ZEROS, CAL_TYPICAL, CAL_ONES,
                                       CAL_INVERTED, CAL_RANDOM, CAL_TYPICAL, CAL_RANDOM};

    pedal_sensor_plausibility_check #(.ADC_BITS(ADC_BITS)) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .raw_a         (raw_a),
        .raw_b         (raw_b),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .done          (done),
        .pos_a         (pos_a),
        .pos_b         (pos_b),
        .diff_fault    (diff_fault),
        .short_fault   (short_fault),
        .similar_fault (similar_fault)
    );

    psc_position_checker #(.ADC_BITS(ADC_BITS), .CFG_W(CFG_W)) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .raw_a          (raw_a),
        .raw_b          (raw_b),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .done           (done),
        .pos_a          (pos_a),
        .pos_b          (pos_b),
        .diff_fault     (diff_fault),
        .short_fault    (short_fault),
        .similar_fault  (similar_fault),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [ADC_BITS-1:0] clamp_raw(input int v);
        if (v < 0)
            return '0;
        if (v > RAW_MAX)
            return ADC_BITS'(RAW_MAX);
        return ADC_BITS'(v);
    endfunction

    task automatic write_reg(input psc_reg_t idx, input logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Write all eight registers from cal_word and refresh the steering ranges
    task automatic program_calibration();
        int ra, fa, rb, fb;
        for (int i = 0; i < 8; i++)
            write_reg(psc_reg_t'(i), cal_word[i]);
        ra      = int'(cal_word[REG_REST_A][ADC_BITS-1:0]);
        fa      = int'(cal_word[REG_FULL_A][ADC_BITS-1:0]);
        rb      = int'(cal_word[REG_REST_B][ADC_BITS-1:0]);
        fb      = int'(cal_word[REG_FULL_B][ADC_BITS-1:0]);
        lo_a    = (ra < fa) ? ra : fa;
        hi_a    = (ra < fa) ? fa : ra;
        lo_b    = (rb < fb) ? rb : fb;
        hi_b    = (rb < fb) ? fb : rb;
        rail_lo = int'(cal_word[REG_RAIL_LOW][ADC_BITS-1:0]);
        rail_hi = int'(cal_word[REG_RAIL_HIGH][ADC_BITS-1:0]);
    endtask

    task automatic choose_calibration(input cal_kind_t kind);
        case (kind)
            CAL_TYPICAL:
            begin
                cal_word[REG_REST_A]    = CFG_W'($urandom_range(200));
                cal_word[REG_FULL_A]    = CFG_W'($urandom_range(RAW_MAX, 800));
                cal_word[REG_REST_B]    = CFG_W'($urandom_range(200));
                cal_word[REG_FULL_B]    = CFG_W'($urandom_range(RAW_MAX, 800));
                cal_word[REG_RAIL_LOW]  = CFG_W'($urandom_range(80, 20));
                cal_word[REG_RAIL_HIGH] = CFG_W'($urandom_range(1000, 940));
                cal_word[REG_MAX_DIFF]  = CFG_W'($urandom_range(150));
                cal_word[REG_MIN_DELTA] = CFG_W'($urandom_range(100));
            end
            CAL_ZEROS:
                for (int i = 0; i < 8; i++)
                    cal_word[i] = '0;
            CAL_ONES:
                for (int i = 0; i < 8; i++)
                    cal_word[i] = '1;
            CAL_INVERTED:
            begin
                cal_word[REG_REST_A]    = CFG_W'($urandom_range(RAW_MAX, 600));
                cal_word[REG_FULL_A]    = CFG_W'($urandom_range(400));
                cal_word[REG_REST_B]    = CFG_W'($urandom_range(RAW_MAX, 600));
                cal_word[REG_FULL_B]    = CFG_W'($urandom_range(400));
                cal_word[REG_RAIL_LOW]  = CFG_W'($urandom_range(60));
                cal_word[REG_RAIL_HIGH] = CFG_W'($urandom_range(RAW_MAX, 960));
                cal_word[REG_MAX_DIFF]  = CFG_W'($urandom_range(SCALE));
                cal_word[REG_MIN_DELTA] = CFG_W'($urandom_range(1 << ADC_BITS));
            end
            default:
                for (int i = 0; i < 8; i++)
                    cal_word[i] = CFG_W'($urandom_range((1 << CFG_W) - 1));
        endcase
    endtask

    // Keep start high across back-to-back transactions; lower it only for a gap
    task automatic send_pair(input logic [ADC_BITS-1:0] a, input logic [ADC_BITS-1:0] b);
        if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        start <= 1'b1;
        raw_a <= a;
        raw_b <= b;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Drop start, wait for every result, then let the pipeline run dry
    task automatic settle();
        int guard;
        start <= 1'b0;
        guard = 0;
        do
        begin
            @(posedge clk);
            guard++;
        end
        while (outstanding != 0 && guard < 2000);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Random sample pair: a plausible pedal sweep, a uniform pair, a near-equal pair or a rail probe
    task automatic send_random_pair();
        int sel, t, a, b;
        sel = $urandom_range(99);
        if (sel < 30)
        begin
            a = $urandom_range(RAW_MAX);
            b = $urandom_range(RAW_MAX);
        end
        else if (sel < 70)
        begin
            t = $urandom_range(SCALE);
            a = lo_a + (t * (hi_a - lo_a)) / SCALE + int'($urandom_range(16)) - 8;
            t = t + int'($urandom_range(300)) - 150;
            b = lo_b + (t * (hi_b - lo_b)) / SCALE + int'($urandom_range(16)) - 8;
        end
        else if (sel < 85)
        begin
            a = $urandom_range(RAW_MAX);
            b = a + int'($urandom_range(120)) - 60;
        end
        else
        begin
            a = ($urandom_range(1) ? rail_lo : rail_hi) + int'($urandom_range(6)) - 3;
            b = $urandom_range(RAW_MAX);
            if ($urandom_range(3) == 0)
                b = $urandom_range(1) ? 0 : RAW_MAX;
            if ($urandom_range(1))
            begin
                t = a;
                a = b;
                b = t;
            end
        end
        send_pair(clamp_raw(a), clamp_raw(b));
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed, reset calibration: rails, similarity edge, difference edge
        send_pair(10'd0, 10'd0);
        send_pair(10'd1023, 10'd1023);
        send_pair(10'd0, 10'd1023);
        send_pair(10'd1023, 10'd0);
        send_pair(10'd50, 10'd200);
        send_pair(10'd51, 10'd200);
        send_pair(10'd975, 10'd800);
        send_pair(10'd974, 10'd800);
        send_pair(10'd500, 10'd550);
        send_pair(10'd500, 10'd549);
        send_pair(10'd549, 10'd500);
        send_pair(10'd300, 10'd402);
        send_pair(10'd300, 10'd403);
        send_pair(10'd682, 10'd341);
        settle();

        // Directed: A with full equal to rest, B with full below rest,
        // upper data bits set on the narrower registers
        cal_word[REG_REST_A]    = 11'd300;
        cal_word[REG_FULL_A]    = 11'd300;
        cal_word[REG_REST_B]    = 11'd800;
        cal_word[REG_FULL_B]    = 11'h400 | 11'd200;
        cal_word[REG_RAIL_LOW]  = 11'h400 | 11'd10;
        cal_word[REG_RAIL_HIGH] = 11'd1000;
        cal_word[REG_MAX_DIFF]  = 11'h400 | 11'd50;
        cal_word[REG_MIN_DELTA] = 11'd1024;
        program_calibration();
        send_pair(10'd0, 10'd0);
        send_pair(10'd300, 10'd800);
        send_pair(10'd1023, 10'd1023);
        send_pair(10'd299, 10'd801);
        send_pair(10'd301, 10'd199);
        send_pair(10'd10, 10'd1000);
        send_pair(10'd11, 10'd999);
        send_pair(10'd512, 10'd512);
        settle();

        // Random phases over a spread of calibrations and sender gap rates
        for (int p = 0; p < 8; p++)
        begin
            choose_calibration(schedule[p]);
            program_calibration();
            case (p % 3)
                0:       sender_idle_pct = 0;
                1:       sender_idle_pct = 64;
                default: sender_idle_pct = 9;
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_random_pair();
            settle();
        end

        if (mismatch_count == 0 && outstanding == 0)
            $display("pedal_sensor_plausibility_check verification clean");
        else
            $display("pedal_sensor_plausibility_check verification failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("pedal_sensor_plausibility_check verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/psc_pkg.sv
hdl/psc_lane.sv
hdl/psc_merge.sv
hdl/pedal_sensor_plausibility_check.sv
tb/sv/psc_position_checker.sv
tb/sv/pedal_sensor_plausibility_check_tb.sv
